// ===== src/gcs_pkg.sv =====
`default_nettype none
package gcs_pkg;

    // Step count limits and defaults
    localparam int CORDIC_STEPS_DEF = 32;
    localparam int ATAN_LEN         = 40;
    localparam int SQRT_STEPS       = 32;

    localparam logic [31:0] FOV_RESET    = 32'd67108864;
    localparam logic [31:0] CORDIC_GAIN  = 32'd652032874;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

    // atan(2^-i), full turn = 2^32
    localparam logic [31:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
        32'd1,         32'd0,         32'd0,         32'd0,        32'd0,
        32'd0,         32'd0,         32'd0,         32'd0,        32'd0
    };

    typedef struct packed {
        logic        [31:0] first_ra;
        logic signed [31:0] first_dec;
        logic        [31:0] second_ra;
        logic signed [31:0] second_dec;
    } t_in;

    typedef struct packed {
        logic [31:0] separation;
        logic        loose_outside;
        logic        beyond_fov;
    } t_out;

endpackage
`default_nettype wire

// ===== src/gcs_sincos.sv =====
`default_nettype none
// Rotation CORDIC, one step per stage, with a tag carried alongside
module gcs_sincos #(
    parameter int CORDIC_STEPS = gcs_pkg::CORDIC_STEPS_DEF,
    parameter int TAG_W        = 1
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire                      i_valid,
    input  wire        [31:0]        i_angle,
    input  wire        [TAG_W-1:0]   i_tag,
    output logic                     o_valid,
    output logic signed [31:0]       o_cos,
    output logic signed [31:0]       o_sin,
    output logic       [TAG_W-1:0]   o_tag
);
    localparam int N = (CORDIC_STEPS > gcs_pkg::ATAN_LEN) ? gcs_pkg::ATAN_LEN : CORDIC_STEPS;

    logic               r_v    [0:N];
    logic signed [32:0] r_x    [0:N];
    logic signed [32:0] r_y    [0:N];
    logic signed [33:0] r_z    [0:N];
    logic               r_flip [0:N];
    logic [TAG_W-1:0]   r_tag  [0:N];

    logic [31:0] n_sum;
    logic        n_flip;
    logic [31:0] n_t;

    // fold the angle into the right half plane
    always_comb begin
        n_sum  = i_angle + gcs_pkg::QUARTER_TURN;
        n_flip = n_sum[31];
        n_t    = n_flip ? (i_angle - gcs_pkg::HALF_TURN) : i_angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_x[0]    <= $signed({1'b0, gcs_pkg::CORDIC_GAIN});
            r_y[0]    <= '0;
            r_z[0]    <= 34'(signed'(n_t));
            r_flip[0] <= n_flip;
            r_tag[0]  <= i_tag;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic signed [32:0] dx, dy, nx, ny;
        logic signed [33:0] nz;
        logic signed [33:0] at;

        always_comb begin
            at = $signed({2'b00, gcs_pkg::ATAN_TAB[k]});
            dx = r_y[k] >>> k;
            dy = r_x[k] >>> k;
            if (r_z[k] >= 0) begin
                nx = r_x[k] - dx;
                ny = r_y[k] + dy;
                nz = r_z[k] - at;
            end else begin
                nx = r_x[k] + dx;
                ny = r_y[k] - dy;
                nz = r_z[k] + at;
            end
            // undo the fold on the last step
            if ((k == N - 1) && r_flip[k]) begin
                nx = -nx;
                ny = -ny;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_x[k+1]    <= nx;
                r_y[k+1]    <= ny;
                r_z[k+1]    <= nz;
                r_flip[k+1] <= r_flip[k];
                r_tag[k+1]  <= r_tag[k];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_cos   = r_x[N][31:0];
    assign o_sin   = r_y[N][31:0];
    assign o_tag   = r_tag[N];
endmodule
`default_nettype wire

// ===== src/gcs_sqrt.sv =====
`default_nettype none
// Floor square root of a 64-bit value, two radicand bits per stage
module gcs_sqrt #(
    parameter int TAG_W = 1
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_en,
    input  wire                    i_valid,
    input  wire       [63:0]       i_value,
    input  wire       [TAG_W-1:0]  i_tag,
    output logic                   o_valid,
    output logic      [31:0]       o_root,
    output logic      [TAG_W-1:0]  o_tag
);
    localparam int S = gcs_pkg::SQRT_STEPS;

    logic             r_v    [0:S];
    logic [63:0]      r_val  [0:S];
    logic [33:0]      r_rem  [0:S];
    logic [31:0]      r_root [0:S];
    logic [TAG_W-1:0] r_tag  [0:S];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_val[0]  <= i_value;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_tag[0]  <= i_tag;
        end
    end

    for (genvar k = 0; k < S; k++) begin : g_step
        logic [35:0] remc, trial;
        logic [33:0] nrem;
        logic [31:0] nroot;

        // restoring step: try (root << 2) | 1 against the shifted remainder
        always_comb begin
            remc  = {r_rem[k], r_val[k][63:62]};
            trial = {2'b00, r_root[k], 2'b01};
            if (remc >= trial) begin
                nrem  = 34'(remc - trial);
                nroot = {r_root[k][30:0], 1'b1};
            end else begin
                nrem  = remc[33:0];
                nroot = {r_root[k][30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_val[k+1]  <= {r_val[k][61:0], 2'b00};
                r_rem[k+1]  <= nrem;
                r_root[k+1] <= nroot;
                r_tag[k+1]  <= r_tag[k];
            end
        end
    end

    assign o_valid = r_v[S];
    assign o_root  = r_root[S];
    assign o_tag   = r_tag[S];
endmodule
`default_nettype wire

// ===== src/gcs_vector.sv =====
`default_nettype none
// Vectoring CORDIC: angle of (zc, r), r >= 0, one step per stage
module gcs_vector #(
    parameter int CORDIC_STEPS = gcs_pkg::CORDIC_STEPS_DEF,
    parameter int TAG_W        = 1
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire                      i_valid,
    input  wire        [31:0]        i_r,
    input  wire signed [33:0]        i_zc,
    input  wire        [TAG_W-1:0]   i_tag,
    output logic                     o_valid,
    output logic signed [35:0]       o_angle,
    output logic       [TAG_W-1:0]   o_tag
);
    localparam int N = (CORDIC_STEPS > gcs_pkg::ATAN_LEN) ? gcs_pkg::ATAN_LEN : CORDIC_STEPS;

    logic               r_v   [0:N];
    logic signed [35:0] r_x   [0:N];
    logic signed [35:0] r_y   [0:N];
    logic signed [35:0] r_a   [0:N];
    logic [TAG_W-1:0]   r_tag [0:N];

    logic signed [35:0] n_r, n_zc;

    always_comb begin
        n_r  = $signed({4'b0000, i_r});
        n_zc = 36'(i_zc);
    end

    // pre-rotate by a quarter turn when zc is negative
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_tag[0] <= i_tag;
            if (n_zc < 0) begin
                r_x[0] <= n_r;
                r_y[0] <= -n_zc;
                r_a[0] <= $signed({4'b0000, gcs_pkg::QUARTER_TURN});
            end else begin
                r_x[0] <= n_zc;
                r_y[0] <= n_r;
                r_a[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic signed [35:0] dx, dy, nx, ny, na, at;

        always_comb begin
            at = $signed({4'b0000, gcs_pkg::ATAN_TAB[k]});
            dx = r_y[k] >>> k;
            dy = r_x[k] >>> k;
            if (r_y[k] > 0) begin
                nx = r_x[k] + dx;
                ny = r_y[k] - dy;
                na = r_a[k] + at;
            end else begin
                nx = r_x[k] - dx;
                ny = r_y[k] + dy;
                na = r_a[k] - at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_x[k+1]   <= nx;
                r_y[k+1]   <= ny;
                r_a[k+1]   <= na;
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_angle = r_a[N];
    assign o_tag   = r_tag[N];
endmodule
`default_nettype wire

// ===== src/great_circle_separation.sv =====
`default_nettype none
// Great-circle separation of two sky positions with field-of-view tests.
// Input channel: i_in_valid / o_in_ready carry one pair of positions per
// transaction (i_in_data). Output channel: o_out_valid / i_out_ready carry one
// result per transaction (o_out_data): separation, loose flag, beyond-fov flag.
// Configuration: i_cfg_we writes i_cfg_data into the radius register at once;
// write it only while no transaction is in flight.
// Throughput: one transaction per cycle while the output is not stalled. Stages: the
// sin/cos CORDIC, five multiply stages, the square root, the atan2 CORDIC and one
// output register, N = min(CORDIC_STEPS, 40) being the steps of each CORDIC.
// Every stage advances together; when the output holds a result that is not
// taken, the whole pipeline and o_in_ready stall, so nothing is lost or
// repeated. Reset clears all valid bits and loads the radius with its default.
module great_circle_separation #(
    parameter int CORDIC_STEPS = gcs_pkg::CORDIC_STEPS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire  gcs_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output gcs_pkg::t_out       o_out_data,
    input  wire                 i_cfg_we,
    input  wire  [31:0]         i_cfg_data
);
    logic        tag_none;
    logic [31:0] r_fov_radius;
    logic        en;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fov_radius <= gcs_pkg::FOV_RESET;
        end else if (i_cfg_we) begin
            r_fov_radius <= i_cfg_data;
        end
    end
    assign tag_none = 1'b0;

    // input side: RA gaps, mean declination, declination gap test
    logic [31:0]        dra, gap_raw, gap;
    logic signed [32:0] ddiff, mid, ddec;
    logic               ddec_big;

    always_comb begin
        dra     = i_in_data.second_ra - i_in_data.first_ra;
        gap_raw = i_in_data.first_ra - i_in_data.second_ra;
        gap     = (gap_raw > gcs_pkg::HALF_TURN) ? (32'd0 - gap_raw) : gap_raw;
        ddiff   = 33'(i_in_data.first_dec) - 33'(i_in_data.second_dec);
        mid     = 33'(i_in_data.second_dec) + (ddiff >>> 1);
        ddec    = (ddiff < 0) ? -ddiff : ddiff;
        ddec_big = ddec > $signed({1'b0, r_fov_radius});
    end

    // four parallel sin/cos pipelines
    logic               v1, v2, vr, vm;
    logic signed [31:0] c1, s1, c2, s2, cr, sr, cm, sm;
    logic [32:0]        mtag;

    gcs_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .TAG_W(1)) u_sc1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_in_valid && en),
        .i_angle(i_in_data.first_dec), .i_tag(tag_none),
        .o_valid(v1), .o_cos(c1), .o_sin(s1), .o_tag()
    );
    gcs_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .TAG_W(1)) u_sc2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_in_valid && en),
        .i_angle(i_in_data.second_dec), .i_tag(tag_none),
        .o_valid(v2), .o_cos(c2), .o_sin(s2), .o_tag()
    );
    gcs_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .TAG_W(1)) u_scr (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_in_valid && en),
        .i_angle(dra), .i_tag(tag_none),
        .o_valid(vr), .o_cos(cr), .o_sin(sr), .o_tag()
    );
    gcs_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .TAG_W(33)) u_scm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_in_valid && en),
        .i_angle(mid[31:0]), .i_tag({ddec_big, gap}),
        .o_valid(vm), .o_cos(cm), .o_sin(sm), .o_tag(mtag)
    );

    // stage T1: products of the sines and cosines
    logic               r_v1;
    logic signed [63:0] r_pcs, r_psc, r_pss, r_pcc, r_pcy;
    logic signed [64:0] r_pm;
    logic signed [31:0] r_cr;
    logic               r_dflag1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= v1 && v2 && vr && vm;
        end
        if (en) begin
            r_pcs    <= 64'(c1) * 64'(s2);
            r_psc    <= 64'(s1) * 64'(c2);
            r_pss    <= 64'(s1) * 64'(s2);
            r_pcc    <= 64'(c1) * 64'(c2);
            r_pcy    <= 64'(c2) * 64'(sr);
            r_pm     <= 65'(cm) * $signed({33'd0, mtag[31:0]});
            r_cr     <= cr;
            r_dflag1 <= mtag[32];
        end
    end

    // stage T2: second products with cos of the RA gap, loose test
    logic               r_v2;
    logic signed [63:0] r_t1, r_t2, r_pcs2, r_pss2;
    logic signed [33:0] r_yv2;
    logic               r_loose2;
    logic signed [63:0] a_sc, a_cc, a_y;
    logic signed [64:0] fov_q;

    always_comb begin
        a_sc  = r_psc >>> 30;
        a_cc  = r_pcc >>> 30;
        a_y   = r_pcy >>> 30;
        fov_q = $signed({3'b000, r_fov_radius, 30'd0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
        if (en) begin
            r_t1     <= 64'(signed'(a_sc[33:0])) * 64'(r_cr);
            r_t2     <= 64'(signed'(a_cc[33:0])) * 64'(r_cr);
            r_pcs2   <= r_pcs;
            r_pss2   <= r_pss;
            r_yv2    <= a_y[33:0];
            r_loose2 <= r_dflag1 || (r_pm > fov_q);
        end
    end

    // stage T3: X and Z
    logic               r_v3;
    logic signed [33:0] r_xv3, r_yv3, r_zv3;
    logic               r_loose3;
    logic signed [63:0] xd, zd;

    always_comb begin
        xd = (r_pcs2 - r_t1) >>> 30;
        zd = (r_pss2 + r_t2) >>> 30;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
        if (en) begin
            r_xv3    <= xd[33:0];
            r_zv3    <= zd[33:0];
            r_yv3    <= r_yv2;
            r_loose3 <= r_loose2;
        end
    end

    // stage T4: squares
    logic               r_v4;
    logic signed [63:0] r_xx, r_yy;
    logic signed [33:0] r_zv4;
    logic               r_loose4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
        if (en) begin
            r_xx     <= 64'(r_xv3) * 64'(r_xv3);
            r_yy     <= 64'(r_yv3) * 64'(r_yv3);
            r_zv4    <= r_zv3;
            r_loose4 <= r_loose3;
        end
    end

    // stage T5: sum of squares, wraps at 64 bits
    logic               r_v5;
    logic [63:0]        r_sum;
    logic signed [33:0] r_zv5;
    logic               r_loose5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= r_v4;
        end
        if (en) begin
            r_sum    <= 64'(r_xx + r_yy);
            r_zv5    <= r_zv4;
            r_loose5 <= r_loose4;
        end
    end

    // square root, then atan2
    logic        vq;
    logic [31:0] root;
    logic [34:0] qtag;
    logic        va;
    logic signed [35:0] ang;
    logic        atag;

    gcs_sqrt #(.TAG_W(35)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v5),
        .i_value(r_sum), .i_tag({r_loose5, r_zv5}),
        .o_valid(vq), .o_root(root), .o_tag(qtag)
    );

    gcs_vector #(.CORDIC_STEPS(CORDIC_STEPS), .TAG_W(1)) u_vec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(vq),
        .i_r(root), .i_zc(signed'(qtag[33:0])), .i_tag(qtag[34]),
        .o_valid(va), .o_angle(ang), .o_tag(atag)
    );

    // output register: clamp and exact radius test
    logic [31:0] sep;

    always_comb begin
        if (ang < 0) begin
            sep = '0;
        end else if (ang > $signed({4'b0000, gcs_pkg::HALF_TURN})) begin
            sep = gcs_pkg::HALF_TURN;
        end else begin
            sep = ang[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= va;
        end
        if (en) begin
            o_out_data.separation    <= sep;
            o_out_data.loose_outside <= atag;
            o_out_data.beyond_fov    <= sep > r_fov_radius;
        end
    end
endmodule
`default_nettype wire

// ===== src/gcs_checker.sv =====
`default_nettype none
// Port-level checks on the separation block
module gcs_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                o_in_ready,
    input wire gcs_pkg::t_in  i_in_data,
    input wire                o_out_valid,
    input wire                i_out_ready,
    input wire gcs_pkg::t_out o_out_data,
    input wire                i_cfg_we,
    input wire [31:0]         i_cfg_data
);
    logic [31:0] r_fov_shadow;

    // shadow of the radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fov_shadow <= gcs_pkg::FOV_RESET;
        end else if (i_cfg_we) begin
            r_fov_shadow <= i_cfg_data;
        end
    end

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // a blocked output stalls the input side
    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while output blocked");

    // exact flag agrees with separation and radius
    a_fov_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.beyond_fov == (o_out_data.separation > r_fov_shadow)))
        else $error("beyond_fov disagrees with separation");

    // separation stays within a half turn
    a_sep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.separation <= gcs_pkg::HALF_TURN)
        else $error("separation beyond half turn");
endmodule

bind great_circle_separation gcs_checker u_gcs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
    .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
);
`default_nettype wire
